### hw/rtl/mdb_pkg.sv
// Shared types, constants and helper functions for the maze builder.
// Used by mdb_ctrl, mdb_datapath and maze_dfs_backtracker; depends on nothing.
package mdb_pkg;

  // Grid geometry.
  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int RAND_BITS = 16;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int RDIM_W = $clog2(MAX_ROWS + 1);
  localparam int CDIM_W = $clog2(MAX_COLS + 1);
  localparam int STK_W  = ROW_W + COL_W;

  // Port field widths.
  localparam int FUNC_W    = 2;
  localparam int RAND_W    = 16;
  localparam int POS_W     = 5;
  localparam int STATUS_W  = 3;
  localparam int WALL_W    = 4;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [RAND_W-1:0] RAND_MASK =
    (RAND_BITS >= RAND_W) ? {RAND_W{1'b1}} : RAND_W'((64'd1 << RAND_BITS) - 64'd1);

  // Reset dimensions, limited to the grid size.
  localparam int RST_ROWS = (32 > MAX_ROWS) ? MAX_ROWS : 32;
  localparam int RST_COLS = (32 > MAX_COLS) ? MAX_COLS : 32;

  // Wall bits and cell values.
  localparam logic [WALL_W-1:0] WALL_N    = 4'd8;
  localparam logic [WALL_W-1:0] WALL_S    = 4'd4;
  localparam logic [WALL_W-1:0] WALL_E    = 4'd2;
  localparam logic [WALL_W-1:0] WALL_WEST = 4'd1;
  localparam logic [WALL_W-1:0] CLOSED = 4'd15;
  localparam logic [WALL_W-1:0] ENTRY  = 4'd7;
  localparam logic [WALL_W-1:0] NO_WALLS = 4'd0;

  // Request functions.
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STS_STARTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_CARVED   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FINISHED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_READ     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_IGNORED  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Directions, in the order neighbors are tried.
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Wall memory read address select.
  localparam logic [2:0] WRD_NONE = 3'd0;
  localparam logic [2:0] WRD_REQ  = 3'd1;
  localparam logic [2:0] WRD_CUR  = 3'd2;
  localparam logic [2:0] WRD_N    = 3'd3;
  localparam logic [2:0] WRD_S    = 3'd4;
  localparam logic [2:0] WRD_E    = 3'd5;
  localparam logic [2:0] WRD_W    = 3'd6;
  localparam logic [2:0] WRD_EXIT = 3'd7;

  // Wall memory write select.
  localparam logic [2:0] WWR_NONE  = 3'd0;
  localparam logic [2:0] WWR_CLEAR = 3'd1;
  localparam logic [2:0] WWR_ENTRY = 3'd2;
  localparam logic [2:0] WWR_CUR   = 3'd3;
  localparam logic [2:0] WWR_NEW   = 3'd4;
  localparam logic [2:0] WWR_EXIT  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load_item;
    logic [2:0]          wall_rd;
    logic [2:0]          wall_wr;
    logic                stk_start;
    logic                stk_pop;
    logic                stk_push_cur;
    logic                stk_push_new;
    logic                cap_cur;
    logic                cap_cur_walls;
    logic [3:0]          cap_open;
    logic                cap_dir;
    logic                cap_exit;
    logic                clr_step;
    logic                gen_set;
    logic                gen_clr;
    logic                rsp_load;
    logic [STATUS_W-1:0] rsp_status;
  } mdb_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              generating;
    logic              stack_empty;
    logic              clr_last;
    logic              any_open;
    logic              rsp_free;
  } mdb_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
  endfunction

  // Wall on the side of the current cell that faces the chosen direction.
  function automatic logic [WALL_W-1:0] dir_wall(input logic [1:0] dir);
    unique case (dir)
      DIR_N:   dir_wall = WALL_N;
      DIR_S:   dir_wall = WALL_S;
      DIR_E:   dir_wall = WALL_E;
      default: dir_wall = WALL_WEST;
    endcase
  endfunction

  // Matching wall on the neighbor's side.
  function automatic logic [WALL_W-1:0] opp_wall(input logic [1:0] dir);
    unique case (dir)
      DIR_N:   opp_wall = WALL_S;
      DIR_S:   opp_wall = WALL_N;
      DIR_E:   opp_wall = WALL_WEST;
      default: opp_wall = WALL_E;
    endcase
  endfunction

endpackage

### hw/rtl/mdb_ctrl.sv
// Sequencing state machine of the maze builder.
// Depends on mdb_pkg; drives the datapath through mdb_ctl_t commands.
module mdb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mdb_pkg::mdb_sts_t sts,
  output mdb_pkg::mdb_ctl_t ctl
);

  localparam logic [4:0] S_INIT_CLR = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DECODE   = 5'd2;
  localparam logic [4:0] S_CLEAR    = 5'd3;
  localparam logic [4:0] S_ENTRY    = 5'd4;
  localparam logic [4:0] S_POP      = 5'd5;
  localparam logic [4:0] S_CUR      = 5'd6;
  localparam logic [4:0] S_RDC      = 5'd7;
  localparam logic [4:0] S_RDN      = 5'd8;
  localparam logic [4:0] S_RDS      = 5'd9;
  localparam logic [4:0] S_RDE      = 5'd10;
  localparam logic [4:0] S_RDW      = 5'd11;
  localparam logic [4:0] S_CAPW     = 5'd12;
  localparam logic [4:0] S_PICK     = 5'd13;
  localparam logic [4:0] S_CARVE1   = 5'd14;
  localparam logic [4:0] S_CARVE2   = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;
  localparam logic [4:0] S_RESULT   = 5'd17;

  logic [4:0]                   state, state_next;
  logic [mdb_pkg::STATUS_W-1:0] res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT_CLR;
      res_status <= mdb_pkg::STS_IGNORED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    ctl             = '0;
    ctl.rsp_status  = res_status;
    unique case (state)
      S_INIT_CLR: begin
        ctl.wall_wr  = mdb_pkg::WWR_CLEAR;
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func == mdb_pkg::FUNC_START) begin
          ctl.stk_start = 1'b1;
          ctl.gen_set   = 1'b1;
          state_next    = S_CLEAR;
        end else if (sts.func == mdb_pkg::FUNC_READ) begin
          ctl.wall_rd     = mdb_pkg::WRD_REQ;
          res_status_next = mdb_pkg::STS_READ;
          state_next      = S_RESULT;
        end else if (sts.func == mdb_pkg::FUNC_STEP && sts.generating) begin
          state_next = S_POP;
        end else begin
          res_status_next = mdb_pkg::STS_IGNORED;
          state_next      = S_RESULT;
        end
      end
      S_CLEAR: begin
        ctl.wall_wr  = mdb_pkg::WWR_CLEAR;
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_ENTRY;
      end
      S_ENTRY: begin
        ctl.wall_wr     = mdb_pkg::WWR_ENTRY;
        res_status_next = mdb_pkg::STS_STARTED;
        state_next      = S_RESULT;
      end
      S_POP: begin
        if (sts.stack_empty) begin
          ctl.wall_rd = mdb_pkg::WRD_EXIT;
          state_next  = S_FIN;
        end else begin
          ctl.stk_pop = 1'b1;
          state_next  = S_CUR;
        end
      end
      S_CUR: begin
        ctl.cap_cur = 1'b1;
        state_next  = S_RDC;
      end
      S_RDC: begin
        ctl.wall_rd = mdb_pkg::WRD_CUR;
        state_next  = S_RDN;
      end
      // Reads are issued one per cycle; each result is captured in the next state.
      S_RDN: begin
        ctl.wall_rd       = mdb_pkg::WRD_N;
        ctl.cap_cur_walls = 1'b1;
        state_next        = S_RDS;
      end
      S_RDS: begin
        ctl.wall_rd     = mdb_pkg::WRD_S;
        ctl.cap_open[0] = 1'b1;
        state_next      = S_RDE;
      end
      S_RDE: begin
        ctl.wall_rd     = mdb_pkg::WRD_E;
        ctl.cap_open[1] = 1'b1;
        state_next      = S_RDW;
      end
      S_RDW: begin
        ctl.wall_rd     = mdb_pkg::WRD_W;
        ctl.cap_open[2] = 1'b1;
        state_next      = S_CAPW;
      end
      S_CAPW: begin
        ctl.cap_open[3] = 1'b1;
        state_next      = S_PICK;
      end
      S_PICK: begin
        if (sts.any_open) begin
          ctl.cap_dir = 1'b1;
          state_next  = S_CARVE1;
        end else begin
          state_next = S_POP;
        end
      end
      S_CARVE1: begin
        ctl.wall_wr      = mdb_pkg::WWR_CUR;
        ctl.stk_push_cur = 1'b1;
        state_next       = S_CARVE2;
      end
      S_CARVE2: begin
        ctl.wall_wr      = mdb_pkg::WWR_NEW;
        ctl.stk_push_new = 1'b1;
        res_status_next  = mdb_pkg::STS_CARVED;
        state_next       = S_RESULT;
      end
      S_FIN: begin
        ctl.wall_wr     = mdb_pkg::WWR_EXIT;
        ctl.cap_exit    = 1'b1;
        ctl.gen_clr     = 1'b1;
        res_status_next = mdb_pkg::STS_FINISHED;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.rsp_free) begin
          ctl.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/mdb_datapath.sv
// Datapath of the maze builder: wall grid and path stack memories, the
// configuration registers, neighbor selection and the response register.
// Depends on mdb_pkg; controlled by mdb_ctrl through mdb_ctl_t.
module mdb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdb_pkg::CFG_W-1:0]       cfg_data,
  input  logic [mdb_pkg::FUNC_W-1:0]      func,
  input  logic [mdb_pkg::RAND_W-1:0]      rand_word,
  input  logic [mdb_pkg::POS_W-1:0]       read_row,
  input  logic [mdb_pkg::POS_W-1:0]       read_col,
  input  mdb_pkg::mdb_ctl_t               ctl,
  output mdb_pkg::mdb_sts_t               sts,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [mdb_pkg::STATUS_W-1:0]    status,
  output logic [mdb_pkg::WALL_W-1:0]      cell_walls,
  output logic [mdb_pkg::POS_W-1:0]       at_row,
  output logic [mdb_pkg::POS_W-1:0]       at_col
);

  // Latched request.
  logic [mdb_pkg::FUNC_W-1:0] item_func;
  logic [mdb_pkg::RAND_W-1:0] item_rand;
  logic [mdb_pkg::POS_W-1:0]  item_row;
  logic [mdb_pkg::POS_W-1:0]  item_col;

  logic [mdb_pkg::RDIM_W-1:0] num_rows;
  logic [mdb_pkg::CDIM_W-1:0] num_cols;
  logic                       generating;
  logic [mdb_pkg::CNT_W-1:0]  stack_count;
  logic [mdb_pkg::ADDR_W-1:0] clr_cnt;
  logic                       clr_last;

  logic [mdb_pkg::ROW_W-1:0]  cur_row, new_row, exit_row;
  logic [mdb_pkg::COL_W-1:0]  cur_col, new_col, exit_col;
  logic [mdb_pkg::WALL_W-1:0] cur_walls, exit_walls;
  logic [3:0]                 open_flags, has_nb;
  logic [1:0]                 dir, dir_pick;

  logic [mdb_pkg::WALL_W-1:0] wall_mem [mdb_pkg::CELLS];
  logic [mdb_pkg::WALL_W-1:0] wall_rdata, wall_wdata;
  logic [mdb_pkg::ADDR_W-1:0] wall_raddr, wall_waddr;
  logic                       wall_we;

  logic [mdb_pkg::STK_W-1:0]  stack_mem [mdb_pkg::CELLS];
  logic [mdb_pkg::STK_W-1:0]  stack_rdata, stk_wdata;
  logic [mdb_pkg::ADDR_W-1:0] stk_waddr;
  logic                       stk_we, stack_full;

  logic [2:0]                 open_cnt, pick, seen;
  logic [mdb_pkg::RAND_W+2:0] prod;
  logic                       read_in_grid;

  function automatic logic [mdb_pkg::RDIM_W-1:0] clamp_rows(
      input logic [mdb_pkg::CFG_W-1:0] v);
    if (v == '0) clamp_rows = mdb_pkg::RDIM_W'(1);
    else if (int'(v) > mdb_pkg::MAX_ROWS) clamp_rows = mdb_pkg::RDIM_W'(mdb_pkg::MAX_ROWS);
    else clamp_rows = mdb_pkg::RDIM_W'(v);
  endfunction

  function automatic logic [mdb_pkg::CDIM_W-1:0] clamp_cols(
      input logic [mdb_pkg::CFG_W-1:0] v);
    if (v == '0) clamp_cols = mdb_pkg::CDIM_W'(1);
    else if (int'(v) > mdb_pkg::MAX_COLS) clamp_cols = mdb_pkg::CDIM_W'(mdb_pkg::MAX_COLS);
    else clamp_cols = mdb_pkg::CDIM_W'(v);
  endfunction

  // Configuration; the grid size stays fixed while a maze is being built.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= mdb_pkg::RDIM_W'(mdb_pkg::RST_ROWS);
      num_cols <= mdb_pkg::CDIM_W'(mdb_pkg::RST_COLS);
    end else if (cfg_wr_en && !generating) begin
      unique case (cfg_index)
        mdb_pkg::REG_NUM_ROWS: num_rows <= clamp_rows(cfg_data);
        mdb_pkg::REG_NUM_COLS: num_cols <= clamp_cols(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_func <= func;
      item_rand <= rand_word;
      item_row  <= read_row;
      item_col  <= read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) generating <= 1'b0;
    else if (ctl.gen_set) generating <= 1'b1;
    else if (ctl.gen_clr) generating <= 1'b0;
  end

  // Sweep counter for the clearing pass.
  assign clr_last = (clr_cnt == mdb_pkg::ADDR_W'(mdb_pkg::CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (ctl.clr_step) clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
  end

  // Neighbor existence for the current cell.
  assign has_nb[0] = (cur_row != '0);
  assign has_nb[1] = ((mdb_pkg::RDIM_W'(cur_row) + 1'b1) < num_rows);
  assign has_nb[2] = ((mdb_pkg::CDIM_W'(cur_col) + 1'b1) < num_cols);
  assign has_nb[3] = (cur_col != '0);

  assign exit_row = mdb_pkg::ROW_W'(num_rows - 1'b1);
  assign exit_col = mdb_pkg::COL_W'(num_cols - 1'b1);

  always_comb begin
    new_row = cur_row;
    new_col = cur_col;
    unique case (dir)
      mdb_pkg::DIR_N: new_row = cur_row - 1'b1;
      mdb_pkg::DIR_S: new_row = cur_row + 1'b1;
      mdb_pkg::DIR_E: new_col = cur_col + 1'b1;
      default:        new_col = cur_col - 1'b1;
    endcase
  end

  // Neighbor choice: index (word * count) >> RAND_BITS among the open ones.
  assign open_cnt = 3'($countones(open_flags));
  assign prod     = (mdb_pkg::RAND_W + 3)'(item_rand & mdb_pkg::RAND_MASK)
                  * (mdb_pkg::RAND_W + 3)'(open_cnt);

  always_comb begin
    pick = 3'(prod >> mdb_pkg::RAND_BITS);
    if (pick >= open_cnt) pick = open_cnt - 3'd1;
    seen     = 3'd0;
    dir_pick = mdb_pkg::DIR_N;
    for (int i = 0; i < 4; i++) begin
      if (open_flags[i]) begin
        if (seen == pick) dir_pick = 2'(i);
        seen = seen + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_cur) {cur_row, cur_col} <= stack_rdata;
    if (ctl.cap_cur_walls) cur_walls <= wall_rdata;
    for (int i = 0; i < 4; i++) begin
      if (ctl.cap_open[i]) open_flags[i] <= has_nb[i] && (wall_rdata == mdb_pkg::CLOSED);
    end
    if (ctl.cap_dir) dir <= dir_pick;
    if (ctl.cap_exit) exit_walls <= wall_rdata & ~mdb_pkg::WALL_S;
  end

  // Wall grid memory: one read port with registered data, one write port.
  always_comb begin
    unique case (ctl.wall_rd)
      mdb_pkg::WRD_REQ:
        wall_raddr = mdb_pkg::cell_addr(mdb_pkg::ROW_W'(item_row), mdb_pkg::COL_W'(item_col));
      mdb_pkg::WRD_CUR:  wall_raddr = mdb_pkg::cell_addr(cur_row, cur_col);
      mdb_pkg::WRD_N:    wall_raddr = mdb_pkg::cell_addr(cur_row - 1'b1, cur_col);
      mdb_pkg::WRD_S:    wall_raddr = mdb_pkg::cell_addr(cur_row + 1'b1, cur_col);
      mdb_pkg::WRD_E:    wall_raddr = mdb_pkg::cell_addr(cur_row, cur_col + 1'b1);
      mdb_pkg::WRD_W:    wall_raddr = mdb_pkg::cell_addr(cur_row, cur_col - 1'b1);
      mdb_pkg::WRD_EXIT: wall_raddr = mdb_pkg::cell_addr(exit_row, exit_col);
      default:           wall_raddr = '0;
    endcase
  end

  always_comb begin
    wall_we    = 1'b1;
    wall_waddr = '0;
    wall_wdata = mdb_pkg::CLOSED;
    unique case (ctl.wall_wr)
      mdb_pkg::WWR_CLEAR: wall_waddr = clr_cnt;
      mdb_pkg::WWR_ENTRY: wall_wdata = mdb_pkg::ENTRY;
      mdb_pkg::WWR_CUR: begin
        wall_waddr = mdb_pkg::cell_addr(cur_row, cur_col);
        wall_wdata = cur_walls & ~mdb_pkg::dir_wall(dir);
      end
      mdb_pkg::WWR_NEW: begin
        wall_waddr = mdb_pkg::cell_addr(new_row, new_col);
        wall_wdata = mdb_pkg::CLOSED & ~mdb_pkg::opp_wall(dir);
      end
      mdb_pkg::WWR_EXIT: begin
        wall_waddr = mdb_pkg::cell_addr(exit_row, exit_col);
        wall_wdata = wall_rdata & ~mdb_pkg::WALL_S;
      end
      default: wall_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (ctl.wall_rd != mdb_pkg::WRD_NONE) wall_rdata <= wall_mem[wall_raddr];
  end

  // Path stack: cells stored as {row, col}.
  assign stack_full = (stack_count >= mdb_pkg::CNT_W'(mdb_pkg::CELLS));

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = stack_count[mdb_pkg::ADDR_W-1:0];
    stk_wdata = {cur_row, cur_col};
    if (ctl.stk_start) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (ctl.stk_push_cur) begin
      stk_we = 1'b1;
    end else if (ctl.stk_push_new && !stack_full) begin
      stk_we    = 1'b1;
      stk_wdata = {new_row, new_col};
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (ctl.stk_pop) begin
      stack_rdata <= stack_mem[stack_count[mdb_pkg::ADDR_W-1:0] - 1'b1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stack_count <= '0;
    else if (ctl.stk_start) stack_count <= mdb_pkg::CNT_W'(1);
    else if (ctl.stk_pop) stack_count <= stack_count - 1'b1;
    else if (ctl.stk_push_cur) stack_count <= stack_count + 1'b1;
    else if (ctl.stk_push_new && !stack_full) stack_count <= stack_count + 1'b1;
  end

  // Response register.
  assign read_in_grid = (int'(item_row) < mdb_pkg::MAX_ROWS)
                     && (int'(item_col) < mdb_pkg::MAX_COLS);

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (ctl.rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp_load) begin
      status <= ctl.rsp_status;
      unique case (ctl.rsp_status)
        mdb_pkg::STS_STARTED: begin
          cell_walls <= mdb_pkg::ENTRY;
          at_row     <= '0;
          at_col     <= '0;
        end
        mdb_pkg::STS_CARVED: begin
          cell_walls <= mdb_pkg::CLOSED & ~mdb_pkg::opp_wall(dir);
          at_row     <= mdb_pkg::POS_W'(new_row);
          at_col     <= mdb_pkg::POS_W'(new_col);
        end
        mdb_pkg::STS_FINISHED: begin
          cell_walls <= exit_walls;
          at_row     <= mdb_pkg::POS_W'(exit_row);
          at_col     <= mdb_pkg::POS_W'(exit_col);
        end
        mdb_pkg::STS_READ: begin
          cell_walls <= read_in_grid ? wall_rdata : mdb_pkg::CLOSED;
          at_row     <= item_row;
          at_col     <= item_col;
        end
        default: begin
          cell_walls <= mdb_pkg::NO_WALLS;
          at_row     <= '0;
          at_col     <= '0;
        end
      endcase
    end
  end

  assign sts.func        = item_func;
  assign sts.generating  = generating;
  assign sts.stack_empty = (stack_count == '0);
  assign sts.clr_last    = clr_last;
  assign sts.any_open    = |open_flags;
  assign sts.rsp_free    = !rsp_valid || !rsp_stall;

endmodule

### hw/rtl/maze_dfs_backtracker.sv
// Top level of the maze builder: request and response channels, config port.
// Depends on mdb_pkg, mdb_ctrl and mdb_datapath.
//
// Builds a maze by randomized depth-first search, one carve per step request,
// and answers one response per request. After reset the block sweeps the
// 1024-cell wall memory, one cell per cycle, and accepts no request during
// that sweep (config writes are taken). A start request repeats that sweep.
// A step pops dead-end cells from the path stack before it carves or
// finishes; for each cell the single read port of the wall memory fetches
// the cell and its four neighbors one per cycle. A finished response sits
// in an output register, so a new request is taken while it waits.
module maze_dfs_backtracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mdb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [mdb_pkg::FUNC_W-1:0]      func,
  input  logic [mdb_pkg::RAND_W-1:0]      rand_word,
  input  logic [mdb_pkg::POS_W-1:0]       read_row,
  input  logic [mdb_pkg::POS_W-1:0]       read_col,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [mdb_pkg::STATUS_W-1:0]    status,
  output logic [mdb_pkg::WALL_W-1:0]      cell_walls,
  output logic [mdb_pkg::POS_W-1:0]       at_row,
  output logic [mdb_pkg::POS_W-1:0]       at_col
);

  mdb_pkg::mdb_ctl_t ctl;
  mdb_pkg::mdb_sts_t sts;

  mdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  mdb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .rand_word  (rand_word),
    .read_row   (read_row),
    .read_col   (read_col),
    .ctl        (ctl),
    .sts        (sts),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cell_walls (cell_walls),
    .at_row     (at_row),
    .at_col     (at_col)
  );

endmodule

### test/maze_checker.sv
// Scoreboard for the maze builder: follows the config port and both channels,
// keeps its own wall grid and path stack, and checks every response in order.
// Depends on mdb_pkg for port widths, function codes and status codes.
module maze_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [mdb_pkg::FUNC_W-1:0]    func,
  input  logic [mdb_pkg::RAND_W-1:0]    rand_word,
  input  logic [mdb_pkg::POS_W-1:0]     read_row,
  input  logic [mdb_pkg::POS_W-1:0]     read_col,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic [mdb_pkg::STATUS_W-1:0]  status,
  input  logic [3:0]                    cell_walls,
  input  logic [mdb_pkg::POS_W-1:0]     at_row,
  input  logic [mdb_pkg::POS_W-1:0]     at_col,
  output int                            fail_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = mdb_pkg::CELLS;
  localparam int COLS  = mdb_pkg::MAX_COLS;
  localparam int REPORT_LIMIT = 10;

  localparam logic [3:0] N_BIT = 4'd8;
  localparam logic [3:0] S_BIT = 4'd4;
  localparam logic [3:0] E_BIT = 4'd2;
  localparam logic [3:0] W_BIT = 4'd1;

  typedef struct packed {
    logic [mdb_pkg::STATUS_W-1:0] status;
    logic [3:0]                   walls;
    logic [mdb_pkg::POS_W-1:0]    row;
    logic [mdb_pkg::POS_W-1:0]    col;
  } maze_rsp_t;

  logic [3:0]                grid [CELLS];
  logic [mdb_pkg::ADDR_W-1:0] trail [CELLS];
  int        depth;
  bit        carving;
  int        rows_used;
  int        cols_used;
  maze_rsp_t awaited [$];
  maze_rsp_t got;
  maze_rsp_t want;

  function automatic int fit_dim(input logic [5:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic void close_all();
    foreach (grid[i]) grid[i] = mdb_pkg::CLOSED;
  endfunction

  // One step of the depth-first search: backtrack past dead ends, then carve
  // into one open neighbor, or open the exit once the path stack is empty.
  function automatic maze_rsp_t next_carve(input logic [mdb_pkg::RAND_W-1:0] word);
    int         cur, r, c, n, pick, nr, nc, nxt, prod;
    logic [1:0] dirs [4];
    maze_rsp_t  o;
    o = '0;
    while (depth > 0) begin
      depth--;
      cur = int'(trail[depth]);
      r = cur / COLS;
      c = cur % COLS;
      n = 0;
      if (r >= 1 && grid[cur - COLS] == mdb_pkg::CLOSED) begin
        dirs[n] = mdb_pkg::DIR_N;
        n++;
      end
      if (r + 1 < rows_used && grid[cur + COLS] == mdb_pkg::CLOSED) begin
        dirs[n] = mdb_pkg::DIR_S;
        n++;
      end
      if (c + 1 < cols_used && grid[cur + 1] == mdb_pkg::CLOSED) begin
        dirs[n] = mdb_pkg::DIR_E;
        n++;
      end
      if (c >= 1 && grid[cur - 1] == mdb_pkg::CLOSED) begin
        dirs[n] = mdb_pkg::DIR_W;
        n++;
      end
      if (n == 0) continue;

      trail[depth] = mdb_pkg::ADDR_W'(cur);
      depth++;
      prod = int'(word & mdb_pkg::RAND_MASK) * n;
      pick = prod >> mdb_pkg::RAND_BITS;
      if (pick >= n) pick = n - 1;
      nr = r;
      nc = c;
      case (dirs[pick])
        mdb_pkg::DIR_N: begin
          nr = r - 1;
          grid[cur] &= ~N_BIT;
          grid[cur - COLS] &= ~S_BIT;
        end
        mdb_pkg::DIR_S: begin
          nr = r + 1;
          grid[cur] &= ~S_BIT;
          grid[cur + COLS] &= ~N_BIT;
        end
        mdb_pkg::DIR_E: begin
          nc = c + 1;
          grid[cur] &= ~E_BIT;
          grid[cur + 1] &= ~W_BIT;
        end
        default: begin
          nc = c - 1;
          grid[cur] &= ~W_BIT;
          grid[cur - 1] &= ~E_BIT;
        end
      endcase
      nxt = nr * COLS + nc;
      trail[depth] = mdb_pkg::ADDR_W'(nxt);
      depth++;
      o.status = mdb_pkg::STS_CARVED;
      o.walls  = grid[nxt];
      o.row    = mdb_pkg::POS_W'(nr);
      o.col    = mdb_pkg::POS_W'(nc);
      return o;
    end

    // Every cell has been visited: the exit is the south wall of the far corner.
    nr = rows_used - 1;
    nc = cols_used - 1;
    nxt = nr * COLS + nc;
    grid[nxt] &= ~S_BIT;
    carving = 1'b0;
    o.status = mdb_pkg::STS_FINISHED;
    o.walls  = grid[nxt];
    o.row    = mdb_pkg::POS_W'(nr);
    o.col    = mdb_pkg::POS_W'(nc);
    return o;
  endfunction

  function automatic maze_rsp_t maze_answer(input logic [mdb_pkg::FUNC_W-1:0] f,
                                            input logic [mdb_pkg::RAND_W-1:0] word,
                                            input logic [mdb_pkg::POS_W-1:0]  rr,
                                            input logic [mdb_pkg::POS_W-1:0]  rc);
    maze_rsp_t o;
    o = '0;
    case (f)
      mdb_pkg::FUNC_START: begin
        close_all();
        grid[0]  = mdb_pkg::ENTRY;
        trail[0] = '0;
        depth    = 1;
        carving  = 1'b1;
        o.status = mdb_pkg::STS_STARTED;
        o.walls  = mdb_pkg::ENTRY;
      end
      mdb_pkg::FUNC_READ: begin
        o.status = mdb_pkg::STS_READ;
        o.walls  = grid[int'(rr) * COLS + int'(rc)];
        o.row    = rr;
        o.col    = rc;
      end
      mdb_pkg::FUNC_STEP: begin
        if (carving) o = next_carve(word);
        else o.status = mdb_pkg::STS_IGNORED;
      end
      default: o.status = mdb_pkg::STS_IGNORED;
    endcase
    return o;
  endfunction

  function automatic void log_mismatch(input bit known, input maze_rsp_t exp_rsp,
                                       input maze_rsp_t act);
    fail_count++;
    if (fail_count > REPORT_LIMIT) return;
    if (known)
      $display("response mismatch: expected status %0d walls %0d at (%0d,%0d),",
               exp_rsp.status, exp_rsp.walls, exp_rsp.row, exp_rsp.col,
               " got status %0d walls %0d at (%0d,%0d)",
               act.status, act.walls, act.row, act.col);
    else
      $display("unexpected response: status %0d walls %0d at (%0d,%0d)",
               act.status, act.walls, act.row, act.col);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      close_all();
      depth     = 0;
      carving   = 1'b0;
      rows_used = mdb_pkg::RST_ROWS;
      cols_used = mdb_pkg::RST_COLS;
      awaited.delete();
    end else begin
      // The grid size is frozen while a build is in progress.
      if (cfg_wr_en && !carving) begin
        if (cfg_index == mdb_pkg::REG_NUM_ROWS)
          rows_used = fit_dim(cfg_data, mdb_pkg::MAX_ROWS);
        else if (cfg_index == mdb_pkg::REG_NUM_COLS)
          cols_used = fit_dim(cfg_data, mdb_pkg::MAX_COLS);
      end
      if (req_valid && !req_stall)
        awaited = {awaited, maze_answer(func, rand_word, read_row, read_col)};
      if (rsp_valid && !rsp_stall) begin
        got = {status, cell_walls, at_row, at_col};
        if (awaited.size() == 0) begin
          log_mismatch(1'b0, got, got);
        end else begin
          want = awaited.pop_front();
          if (got !== want) log_mismatch(1'b1, want, got);
        end
      end
    end
    outstanding <= awaited.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for maze_dfs_backtracker: clock, reset, request traffic with
// bursts and gaps, response back-pressure and the verdict. Depends on mdb_pkg,
// the maze builder RTL and maze_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [mdb_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [mdb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mdb_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                          req_valid = 1'b0;
  logic [mdb_pkg::FUNC_W-1:0]    func      = '0;
  logic [mdb_pkg::RAND_W-1:0]    rand_word = '0;
  logic [mdb_pkg::POS_W-1:0]     read_row  = '0;
  logic [mdb_pkg::POS_W-1:0]     read_col  = '0;
  logic                          rsp_stall = 1'b0;
  logic                          req_stall;
  logic                          rsp_valid;
  logic [mdb_pkg::STATUS_W-1:0]  status;
  logic [3:0]                    cell_walls;
  logic [mdb_pkg::POS_W-1:0]     at_row;
  logic [mdb_pkg::POS_W-1:0]     at_col;
  int                            fail_count;
  int                            outstanding;

  int cycles     = 0;
  int stall_pct  = 0;
  int phase_left = 0;
  int hold_left  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;

  int sent       = 0;
  int burst_left = 0;
  int rows_eff   = mdb_pkg::RST_ROWS;
  int cols_eff   = mdb_pkg::RST_COLS;
  int cells_left = 0;
  bit building   = 1'b0;

  maze_dfs_backtracker i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .rand_word  (rand_word),
    .read_row   (read_row),
    .read_col   (read_col),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cell_walls (cell_walls),
    .at_row     (at_row),
    .at_col     (at_col)
  );

  maze_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .rand_word   (rand_word),
    .read_row    (read_row),
    .read_col    (read_col),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .cell_walls  (cell_walls),
    .at_row      (at_row),
    .at_col      (at_col),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Response back-pressure: phases of random length, each with its own stall
  // rate, and a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(8, 150);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 30;
          3:       stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        phase_left <= phase_left - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic int fit_dim(input logic [5:0] v, input int limit);
    return (v == 0) ? 1 : ((v > limit) ? limit : int'(v));
  endfunction

  function automatic logic [mdb_pkg::RAND_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return mdb_pkg::RAND_W'($urandom);
    endcase
  endfunction

  // Offers one request transaction and returns at the edge that accepts it.
  task automatic offer(input logic [mdb_pkg::FUNC_W-1:0] f,
                       input logic [mdb_pkg::RAND_W-1:0] w,
                       input logic [mdb_pkg::POS_W-1:0]  r,
                       input logic [mdb_pkg::POS_W-1:0]  c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    func      <= f;
    rand_word <= w;
    read_row  <= r;
    read_col  <= c;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Both registers, on back-to-back cycles; only call with the block idle.
  task automatic set_size(input logic [5:0] rows_raw, input logic [5:0] cols_raw);
    cfg_wr_en <= 1'b1;
    cfg_index <= mdb_pkg::REG_NUM_ROWS;
    cfg_data  <= rows_raw;
    @(posedge clk);
    cfg_index <= mdb_pkg::REG_NUM_COLS;
    cfg_data  <= cols_raw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (!building) begin
      rows_eff = fit_dim(rows_raw, mdb_pkg::MAX_ROWS);
      cols_eff = fit_dim(cols_raw, mdb_pkg::MAX_COLS);
    end
  endtask

  task automatic begin_maze();
    offer(mdb_pkg::FUNC_START, pick_word(), mdb_pkg::POS_W'($urandom),
          mdb_pkg::POS_W'($urandom));
    building   = 1'b1;
    cells_left = rows_eff * cols_eff;
  endtask

  // A build of N cells takes N-1 carving steps and one finishing step.
  task automatic carve(input logic [mdb_pkg::RAND_W-1:0] w);
    offer(mdb_pkg::FUNC_STEP, w, mdb_pkg::POS_W'($urandom), mdb_pkg::POS_W'($urandom));
    if (building) begin
      cells_left--;
      if (cells_left == 0) building = 1'b0;
    end
  endtask

  task automatic read_any();
    offer(mdb_pkg::FUNC_READ, pick_word(), mdb_pkg::POS_W'($urandom),
          mdb_pkg::POS_W'($urandom));
  endtask

  task automatic mixed_item(input bit restarts);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) begin
      carve(pick_word());
    end else if (roll < 90) begin
      read_any();
    end else if (roll < 95) begin
      offer(FUNC_UNUSED, pick_word(), mdb_pkg::POS_W'($urandom),
            mdb_pkg::POS_W'($urandom));
    end else if (roll < 97) begin
      // Size writes in the middle of a build must have no effect.
      drain();
      set_size(mdb_pkg::CFG_W'($urandom), mdb_pkg::CFG_W'($urandom));
    end else if (restarts) begin
      begin_maze();
    end else begin
      carve(pick_word());
    end
  endtask

  initial begin
    logic [5:0] rows_raw, cols_raw;
    int         sel;
    int         build_no;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset size of 32 by 32.
    carve('1);
    offer(FUNC_UNUSED, '0, '1, '1);
    offer(mdb_pkg::FUNC_READ, '1, '0, '0);
    offer(mdb_pkg::FUNC_READ, '0, '1, '1);

    // Zero counts as one: a single-cell maze finishes on its first step.
    drain();
    set_size('0, '0);
    begin_maze();
    carve('0);
    carve(16'h8000);

    drain();
    set_size(6'd2, 6'd2);
    begin_maze();
    carve('1);
    offer(mdb_pkg::FUNC_READ, '0, 5'd1, 5'd1);
    drain();
    set_size('0, '1);
    carve('0);
    carve(16'h8000);
    offer(FUNC_UNUSED, '1, '0, '0);
    carve('1);
    begin_maze();
    carve(pick_word());
    begin_maze();
    repeat (4) carve(pick_word());
    offer(mdb_pkg::FUNC_READ, '0, 5'd1, 5'd1);
    carve('1);

    // Random part: complete builds of mostly small, sometimes long and thin mazes.
    build_no = 0;
    while (sent < ITEM_TARGET - 80) begin
      drain();
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        rows_raw = mdb_pkg::CFG_W'($urandom_range(32, 63));
        cols_raw = mdb_pkg::CFG_W'($urandom_range(0, 2));
      end else if (sel < 8) begin
        rows_raw = mdb_pkg::CFG_W'($urandom_range(0, 2));
        cols_raw = mdb_pkg::CFG_W'($urandom_range(32, 63));
      end else begin
        rows_raw = mdb_pkg::CFG_W'($urandom_range(0, 7));
        cols_raw = mdb_pkg::CFG_W'($urandom_range(0, 7));
      end
      set_size(rows_raw, cols_raw);
      if (build_no % 20 == 7) hold_req <= hold_req + 1;
      begin_maze();
      while (building) mixed_item(rows_eff * cols_eff <= 16);
      repeat ($urandom_range(0, 2)) carve(pick_word());
      build_no++;
    end

    // Part of a full-size build to exercise deep paths in the largest grid.
    drain();
    set_size(6'd32, 6'd32);
    begin_maze();
    repeat (70) mixed_item(1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
